/* hdl/ima_pkg.sv */
// Shared types, constants and step table of the IMA ADPCM decoder.
// No dependencies; used by ima_front, ima_back and ima_adpcm_decoder.
package ima_pkg;

  localparam int unsigned IDX_W     = 7;
  localparam int unsigned PRED_W    = 16;
  localparam int unsigned STEP_W    = 15;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

  localparam logic [CFG_ADDR_W-1:0] CFG_STEREO_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_PRED_0  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_INDEX_0 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_PRED_1  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_INDEX_1 = 3'd4;

  typedef struct packed {
    logic                     stereo_mode;
    logic signed [PRED_W-1:0] start_pred_0;
    logic        [IDX_W-1:0]  start_index_0;
    logic signed [PRED_W-1:0] start_pred_1;
    logic        [IDX_W-1:0]  start_index_1;
  } cfg_t;

  // One queued input byte, classified by the front part
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
    logic       block_end;
    logic       two_nib;   // high nibble is decoded as well
    logic       hi_ch;     // channel of the high nibble
  } item_t;

  localparam logic [STEP_W-1:0] STEP_TAB [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [IDX_W-1:0] sat_index(input logic [IDX_W-1:0] idx);
    return (idx > IDX_MAX) ? IDX_MAX : idx;
  endfunction

  function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] i;
    i = sat_index(idx);
    return STEP_TAB[i];
  endfunction

  // Index adjustment: -1 for magnitudes 0..3, then 2, 4, 6, 8
  function automatic logic signed [4:0] idx_delta(input logic [2:0] mag);
    logic [3:0] up;
    up = {1'b0, mag[1:0], 1'b0} + 4'd2;
    return mag[2] ? $signed({1'b0, up}) : -5'sd1;
  endfunction

endpackage

/* hdl/ima_adpcm_decoder.sv */
// IMA ADPCM 4-bit decoder top level: configuration registers, front queue, back decoder.
// An input byte is written into the front queue and then decoded from there into the output register.
// Throughput: one result per cycle while the queue holds data and the output is not stalled, set by the single
// nibble-step unit in ima_back; a byte with two nibbles gives one result per nibble.
// Reset: synchronous, active low; clears registers, channel state and the queue.
// Depends on ima_pkg, ima_front and ima_back.
module ima_adpcm_decoder #(
  parameter int unsigned QUEUE_DEPTH = ima_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ima_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ima_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte[7:0]
  input  logic [1:0]                     in_tuser,   // block_start, high_valid
  input  logic                           in_tlast,   // block_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // sample[15:0], channel, index_after[6:0]
  output logic                           out_tuser,  // item_last
  output logic                           out_tlast   // block_last
);

  ima_pkg::cfg_t  cfg_r;
  logic           q_valid, q_pop;
  ima_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ima_pkg::CFG_STEREO_MODE:   cfg_r.stereo_mode   <= cfg_wdata[0];
        ima_pkg::CFG_START_PRED_0:  cfg_r.start_pred_0  <= cfg_wdata;
        ima_pkg::CFG_START_INDEX_0: cfg_r.start_index_0 <= cfg_wdata[ima_pkg::IDX_W-1:0];
        ima_pkg::CFG_START_PRED_1:  cfg_r.start_pred_1  <= cfg_wdata;
        ima_pkg::CFG_START_INDEX_1: cfg_r.start_index_1 <= cfg_wdata[ima_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  ima_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .stereo_mode(cfg_r.stereo_mode),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  ima_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

/* hdl/ima_front.sv */
// Front part: accepts input bytes, classifies them and queues them.
// Depends on ima_pkg.
module ima_front #(
  parameter int unsigned DEPTH = ima_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           stereo_mode,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // data_byte[7:0]
  input  logic [1:0]     in_tuser,   // block_start, high_valid
  input  logic           in_tlast,   // block_end
  output logic           q_valid,
  output ima_pkg::item_t q_item,
  input  logic           q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ima_pkg::item_t   mem_r [DEPTH];
  ima_pkg::item_t   item_in;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;

  assign in_tready = (count_r != CNT_FULL);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    item_in.data_byte   = in_tdata;
    item_in.block_start = in_tuser[0];
    item_in.block_end   = in_tlast;
    item_in.two_nib     = stereo_mode | in_tuser[1];
    item_in.hi_ch       = stereo_mode;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* hdl/ima_back.sv */
// Back part: decodes one nibble per cycle into the output register while the output is not stalled.
// Holds predictor and step index of both channels. Depends on ima_pkg.
module ima_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ima_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  ima_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [23:0]    out_tdata,  // sample[15:0], channel, index_after[6:0]
  output logic           out_tuser,  // item_last
  output logic           out_tlast   // block_last
);

  logic signed [ima_pkg::PRED_W-1:0] pred_r [2];
  logic        [ima_pkg::IDX_W-1:0]  idx_r  [2];
  logic                              phase_r, phase_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [ima_pkg::PRED_W-1:0] out_sample_r;
  logic                              out_ch_r, out_item_last_r, out_block_last_r;
  logic        [ima_pkg::IDX_W-1:0]  out_idx_r;

  logic                              advance, last_nib, reload, ch;
  logic        [3:0]                 nib;
  logic signed [ima_pkg::PRED_W-1:0] cur_pred;
  logic        [ima_pkg::IDX_W-1:0]  cur_idx;
  logic        [ima_pkg::STEP_W-1:0] step;
  logic        [16:0]                diff;
  logic signed [17:0]                sum;
  logic signed [ima_pkg::PRED_W-1:0] new_pred;
  logic signed [7:0]                 adv;
  logic        [ima_pkg::IDX_W-1:0]  new_idx;

  assign advance  = q_valid && (!out_valid_r || out_tready);
  assign last_nib = phase_r || !q_item.two_nib;
  assign q_pop    = advance && last_nib;
  assign reload   = q_item.block_start && !phase_r;
  assign ch       = phase_r & q_item.hi_ch;
  assign nib      = phase_r ? q_item.data_byte[7:4] : q_item.data_byte[3:0];

  always_comb begin
    if (reload) begin
      cur_pred = ch ? cfg.start_pred_1 : cfg.start_pred_0;
      cur_idx  = ima_pkg::sat_index(ch ? cfg.start_index_1 : cfg.start_index_0);
    end else begin
      cur_pred = pred_r[ch];
      cur_idx  = idx_r[ch];
    end
    step = ima_pkg::step_of(cur_idx);

    adv = $signed({1'b0, cur_idx}) + 8'(ima_pkg::idx_delta(nib[2:0]));
    if (adv < 0) begin
      new_idx = '0;
    end else if (adv > $signed({1'b0, ima_pkg::IDX_MAX})) begin
      new_idx = ima_pkg::IDX_MAX;
    end else begin
      new_idx = adv[ima_pkg::IDX_W-1:0];
    end

    diff = 17'(step >> 3);
    if (nib[2]) diff = diff + 17'(step);
    if (nib[1]) diff = diff + 17'(step >> 1);
    if (nib[0]) diff = diff + 17'(step >> 2);

    if (nib[3]) begin
      sum = 18'(cur_pred) - $signed({1'b0, diff});
    end else begin
      sum = 18'(cur_pred) + $signed({1'b0, diff});
    end
    if (sum > 18'sd32767) begin
      new_pred = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      new_pred = 16'sh8000;
    end else begin
      new_pred = sum[ima_pkg::PRED_W-1:0];
    end

    phase_nxt     = advance ? !last_nib : phase_r;
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r[0]   <= '0;
      pred_r[1]   <= '0;
      idx_r[0]    <= '0;
      idx_r[1]    <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        // block start on the low nibble reloads the other channel too
        if (reload) begin
          pred_r[1] <= cfg.start_pred_1;
          idx_r[1]  <= ima_pkg::sat_index(cfg.start_index_1);
        end
        pred_r[ch] <= new_pred;
        idx_r[ch]  <= new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample_r     <= new_pred;
      out_ch_r         <= ch;
      out_idx_r        <= new_idx;
      out_item_last_r  <= last_nib;
      out_block_last_r <= last_nib && q_item.block_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_idx_r, out_ch_r, out_sample_r};
  assign out_tuser  = out_item_last_r;
  assign out_tlast  = out_block_last_r;

endmodule
